/* src/tfn_pkg.sv */
// shared types and constants for the triangle face normal unit
package tfn_pkg;

	localparam int COORD_BITS       = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int OUT_BITS         = NORMAL_FRAC_BITS + 2;
	localparam int EDGE_BITS        = COORD_BITS + 1;
	localparam int PROD_BITS        = 2 * EDGE_BITS;
	localparam int MAG_BITS         = PROD_BITS;
	localparam int POS_BITS         = 6;
	localparam int WIN_BITS         = 30;
	localparam int SQ_BITS          = 2 * WIN_BITS;
	localparam int SUM_BITS         = SQ_BITS + 2;
	localparam int ROOT_BITS        = 64;
	localparam int SQRT_STEPS       = 32;
	localparam int DIV_STEPS        = 16;
	localparam int REM_BITS         = WIN_BITS + NORMAL_FRAC_BITS + 3;
	localparam int R_BITS           = 31;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] v0_x;
		logic signed [COORD_BITS-1:0] v0_y;
		logic signed [COORD_BITS-1:0] v0_z;
		logic signed [COORD_BITS-1:0] v1_x;
		logic signed [COORD_BITS-1:0] v1_y;
		logic signed [COORD_BITS-1:0] v1_z;
		logic signed [COORD_BITS-1:0] v2_x;
		logic signed [COORD_BITS-1:0] v2_y;
		logic signed [COORD_BITS-1:0] v2_z;
	} face_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] normal_x;
		logic signed [OUT_BITS-1:0] normal_y;
		logic signed [OUT_BITS-1:0] normal_z;
		logic                       degenerate;
	} norm_t;

	// per-item values carried alongside the root and divide stages
	typedef struct packed {
		logic [2:0][WIN_BITS-1:0] t;
		logic [2:0]               neg;
		logic                     deg;
	} side_t;

endpackage

/* src/triangle_face_normal_unit.sv */
// top level: pipelined unit face normal of a triangle
// usage
// - face channel: face_valid/face_stall with the three corners packed in face,
//   signed q7.8 coordinates; a transaction completes when valid is high and
//   stall is low
// - norm channel: norm_valid/norm_stall with the unit normal in signed q1.14
//   and a degenerate flag for a zero cross product (normal then all zero)
// - 56 register stages; one face can enter every cycle unless face_stall is
//   high, so throughput is one transaction per cycle while the pipe is not
//   stalled
// - the stage count is set by the square root (32 stages, two bits of the radicand
//   per stage) and the divider (16 stages, one quotient bit per stage), fed
//   by edge, multiply, cross, leading-one, scale, square and sum stages
// - the whole pipe advances together; when the last stage holds a result and
//   norm_stall is high, every stage holds and face_stall goes high
// - reset clears all valid bits; payload registers are not reset
module triangle_face_normal_unit
	import tfn_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  face_valid,
	output logic  face_stall,
	input  face_t face,
	output logic  norm_valid,
	input  logic  norm_stall,
	output norm_t norm
);

	// stage count: 7 front stages, sqrt, divide, output register
	localparam int NSTG = 7 + SQRT_STEPS + DIV_STEPS + 1;

	logic [NSTG-1:0] vld_q;
	logic            en;

	// global advance: the pipe moves unless a finished result is held
	assign en         = !vld_q[NSTG-1] || !norm_stall;
	assign face_stall = !en;
	assign norm_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], face_valid};
		end
	end

	// stage 1: edge vectors a = v1 - v0, b = v2 - v0
	logic signed [EDGE_BITS-1:0] a_s1 [3];
	logic signed [EDGE_BITS-1:0] b_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= EDGE_BITS'(face.v1_x) - EDGE_BITS'(face.v0_x);
			a_s1[1] <= EDGE_BITS'(face.v1_y) - EDGE_BITS'(face.v0_y);
			a_s1[2] <= EDGE_BITS'(face.v1_z) - EDGE_BITS'(face.v0_z);
			b_s1[0] <= EDGE_BITS'(face.v2_x) - EDGE_BITS'(face.v0_x);
			b_s1[1] <= EDGE_BITS'(face.v2_y) - EDGE_BITS'(face.v0_y);
			b_s1[2] <= EDGE_BITS'(face.v2_z) - EDGE_BITS'(face.v0_z);
		end
	end

	// stage 2: six partial products of the cross product
	logic signed [PROD_BITS-1:0] p_s2 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= a_s1[1] * b_s1[2];
			p_s2[1] <= a_s1[2] * b_s1[1];
			p_s2[2] <= a_s1[2] * b_s1[0];
			p_s2[3] <= a_s1[0] * b_s1[2];
			p_s2[4] <= a_s1[0] * b_s1[1];
			p_s2[5] <= a_s1[1] * b_s1[0];
		end
	end

	// stage 3: cross product, split into magnitude and sign
	logic signed [PROD_BITS:0] c_cross [3];
	logic [MAG_BITS-1:0]       t_s3 [3];
	logic [2:0]                neg_s3;
	logic                      deg_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_cross[i] = (PROD_BITS+1)'(p_s2[2*i]) - (PROD_BITS+1)'(p_s2[2*i+1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t_s3[i]   <= c_cross[i][PROD_BITS] ? MAG_BITS'(-c_cross[i])
				                                  : MAG_BITS'(c_cross[i]);
				neg_s3[i] <= c_cross[i][PROD_BITS];
			end
			deg_s3 <= (c_cross[0] == '0) && (c_cross[1] == '0) && (c_cross[2] == '0);
		end
	end

	// stage 4: leading one of the largest magnitude
	logic [MAG_BITS-1:0] any_mag;
	logic [POS_BITS-1:0] pos_c;
	logic [POS_BITS-1:0] pos_s4;
	logic [MAG_BITS-1:0] t_s4 [3];
	logic [2:0]          neg_s4;
	logic                deg_s4;

	always_comb begin
		any_mag = t_s3[0] | t_s3[1] | t_s3[2];
		pos_c   = '0;
		for (int i = 0; i < MAG_BITS; i++) begin
			if (any_mag[i]) begin
				pos_c = POS_BITS'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s4 <= pos_c;
			t_s4   <= t_s3;
			neg_s4 <= neg_s3;
			deg_s4 <= deg_s3;
		end
	end

	// stage 5: scale so the largest magnitude sits in [2^29, 2^30)
	localparam logic [POS_BITS-1:0] WIN_TOP = POS_BITS'(WIN_BITS - 1);

	side_t side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (pos_s4 < WIN_TOP) begin
					side_s5.t[i] <= WIN_BITS'(t_s4[i] << (WIN_TOP - pos_s4));
				end else begin
					side_s5.t[i] <= WIN_BITS'(t_s4[i] >> (pos_s4 - WIN_TOP));
				end
			end
			side_s5.neg <= neg_s4;
			side_s5.deg <= deg_s4;
		end
	end

	// stage 6: squares
	logic [SQ_BITS-1:0] sq_s6 [3];
	side_t              side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= side_s5.t[i] * side_s5.t[i];
			end
			side_s6 <= side_s5;
		end
	end

	// stage 7: squared length
	logic [SUM_BITS-1:0] sum_s7;
	side_t               side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7  <= SUM_BITS'(sq_s6[0]) + SUM_BITS'(sq_s6[1]) + SUM_BITS'(sq_s6[2]);
			side_s7 <= side_s6;
		end
	end

	// square root: one radicand digit pair per stage
	logic [ROOT_BITS-1:0] rx_s [SQRT_STEPS+1];
	logic [ROOT_BITS-1:0] rr_s [SQRT_STEPS+1];
	side_t                rside_s [SQRT_STEPS+1];

	assign rx_s[0]    = ROOT_BITS'(sum_s7);
	assign rr_s[0]    = '0;
	assign rside_s[0] = side_s7;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [ROOT_BITS-1:0] BIT = ROOT_BITS'(1) << (2 * (SQRT_STEPS - 1 - j));
		logic [ROOT_BITS-1:0] trial;

		assign trial = rr_s[j] + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rx_s[j] >= trial) begin
					rx_s[j+1] <= rx_s[j] - trial;
					rr_s[j+1] <= (rr_s[j] >> 1) + BIT;
				end else begin
					rx_s[j+1] <= rx_s[j];
					rr_s[j+1] <= rr_s[j] >> 1;
				end
				rside_s[j+1] <= rside_s[j];
			end
		end
	end

	// divider: (t * 2^F + r/2) / r, one quotient bit per stage, three lanes
	logic [R_BITS-1:0]    root;
	logic [REM_BITS-1:0]  rem_s [DIV_STEPS+1][3];
	logic [DIV_STEPS-1:0] q_s   [DIV_STEPS+1][3];
	logic [R_BITS-1:0]    dr_s  [DIV_STEPS+1];
	side_t                dside_s [DIV_STEPS+1];

	assign root = R_BITS'(rr_s[SQRT_STEPS]);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i] = (REM_BITS'(rside_s[SQRT_STEPS].t[i]) << NORMAL_FRAC_BITS)
			              + REM_BITS'(root >> 1);
			q_s[0][i]   = '0;
		end
	end
	assign dr_s[0]    = root;
	assign dside_s[0] = rside_s[SQRT_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int QB = DIV_STEPS - 1 - k;
		logic [REM_BITS-1:0] dvs;

		assign dvs = REM_BITS'(dr_s[k]) << QB;

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_s[k][i] >= dvs) begin
						rem_s[k+1][i] <= rem_s[k][i] - dvs;
						q_s[k+1][i]   <= q_s[k][i] | (DIV_STEPS'(1) << QB);
					end else begin
						rem_s[k+1][i] <= rem_s[k][i];
						q_s[k+1][i]   <= q_s[k][i];
					end
				end
				dr_s[k+1]    <= dr_s[k];
				dside_s[k+1] <= dside_s[k];
			end
		end
	end

	// output register: saturate to one, apply sign, force zero on degenerate
	localparam logic [DIV_STEPS-1:0] ONE_Q = DIV_STEPS'(1) << NORMAL_FRAC_BITS;

	logic [OUT_BITS-1:0] nrm [3];
	norm_t               out_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nrm[i] = (q_s[DIV_STEPS][i] > ONE_Q) ? OUT_BITS'(ONE_Q)
			                                     : OUT_BITS'(q_s[DIV_STEPS][i]);
			if (dside_s[DIV_STEPS].neg[i]) begin
				nrm[i] = -nrm[i];
			end
			if (dside_s[DIV_STEPS].deg) begin
				nrm[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.normal_x   <= nrm[0];
			out_q.normal_y   <= nrm[1];
			out_q.normal_z   <= nrm[2];
			out_q.degenerate <= dside_s[DIV_STEPS].deg;
		end
	end

	assign norm = out_q;

`ifndef SYNTH
	// a held result must stall the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && norm_stall |-> face_stall)
		else $error("input not stalled while result held");

	// a degenerate face yields an all-zero normal
	assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && norm.degenerate |->
		norm.normal_x == '0 && norm.normal_y == '0 && norm.normal_z == '0)
		else $error("degenerate face with nonzero normal");

	// components stay within plus or minus one
	assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid |->
		norm.normal_x <= 16'sd16384 && norm.normal_x >= -16'sd16384 &&
		norm.normal_y <= 16'sd16384 && norm.normal_y >= -16'sd16384 &&
		norm.normal_z <= 16'sd16384 && norm.normal_z >= -16'sd16384)
		else $error("normal component out of range");
`endif

endmodule

/* tb/testbench.sv */
// testbench for the triangle face normal unit: directed and random faces checked against a predictor
module testbench;
	import tfn_pkg::*;

	logic  clk;
	logic  arst_n;
	logic  face_valid;
	logic  face_stall;
	face_t face;
	logic  norm_valid;
	logic  norm_stall;
	norm_t norm;

	// expected normals, oldest first
	norm_t expected_normals[$];
	int    mismatch_count;
	int    cycle_count;
	bit    hold_off;       // long receiver hold-off request
	bit    random_stall;   // receiver stall pattern enabled
	int    max_gap;        // longest gap between sender bursts

	localparam int CYCLE_LIMIT = 400000;

	triangle_face_normal_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.face_valid (face_valid),
		.face_stall (face_stall),
		.face       (face),
		.norm_valid (norm_valid),
		.norm_stall (norm_stall),
		.norm       (norm)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// integer square root, bit by bit
	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// unit normal of one face
	function automatic norm_t face_normal(face_t f);
		longint          ax, ay, az, bx, by, bz;
		longint          cr[3];
		longint unsigned tm[3];
		longint unsigned m, s, r, q;
		norm_t           res;
		logic signed [OUT_BITS-1:0] comp[3];
		ax = longint'(f.v1_x) - longint'(f.v0_x);
		ay = longint'(f.v1_y) - longint'(f.v0_y);
		az = longint'(f.v1_z) - longint'(f.v0_z);
		bx = longint'(f.v2_x) - longint'(f.v0_x);
		by = longint'(f.v2_y) - longint'(f.v0_y);
		bz = longint'(f.v2_z) - longint'(f.v0_z);
		cr[0] = ay * bz - az * by;
		cr[1] = az * bx - ax * bz;
		cr[2] = ax * by - ay * bx;
		res = '0;
		if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
			res.degenerate = 1'b1;
			return res;
		end
		m = 0;
		for (int i = 0; i < 3; i++) begin
			tm[i] = cr[i] < 0 ? unsigned'(-cr[i]) : unsigned'(cr[i]);
			if (tm[i] > m)
				m = tm[i];
		end
		// scale into the magnitude window
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++)
				tm[i] <<= 1;
		end
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++)
				tm[i] >>= 1;
		end
		s = tm[0] * tm[0] + tm[1] * tm[1] + tm[2] * tm[2];
		r = root_floor(s);
		for (int i = 0; i < 3; i++) begin
			q = ((tm[i] << NORMAL_FRAC_BITS) + (r >> 1)) / r;
			if (q > (64'd1 << NORMAL_FRAC_BITS))
				q = 64'd1 << NORMAL_FRAC_BITS;
			if (cr[i] < 0)
				q = -q;
			comp[i] = q[OUT_BITS-1:0];
		end
		res.normal_x = comp[0];
		res.normal_y = comp[1];
		res.normal_z = comp[2];
		return res;
	endfunction

	// send one face, waiting for the transaction to complete
	task automatic send_face(face_t f);
		face <= f;
		face_valid <= 1'b1;
		expected_normals.insert(expected_normals.size(), face_normal(f));
		@(posedge clk);
		while (face_stall)
			@(posedge clk);
	endtask

	// drop valid, then idle for the gap given by the caller
	task automatic pause_sender(int n);
		face_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// one random face from a caller-selected generator kind
	function automatic face_t random_face(int kind);
		face_t f;
		logic [15:0] d;
		f = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
		case (kind)
			0: begin
				// small triangle around a random point
				d = 16'($urandom_range(0, 63));
				f.v1_x = f.v0_x + 16'($signed(d) - 32);
				f.v1_y = f.v0_y + 16'($urandom_range(0, 63)) - 16'd32;
				f.v1_z = f.v0_z + 16'($urandom_range(0, 63)) - 16'd32;
				f.v2_x = f.v0_x + 16'($urandom_range(0, 63)) - 16'd32;
				f.v2_y = f.v0_y + 16'($urandom_range(0, 63)) - 16'd32;
				f.v2_z = f.v0_z + 16'($urandom_range(0, 63)) - 16'd32;
			end
			1: begin
				// collinear corners: v2 = v0 + k*(v1 - v0) within range
				f.v0_x = 16'($urandom_range(0, 2000)) - 16'd1000;
				f.v0_y = 16'($urandom_range(0, 2000)) - 16'd1000;
				f.v0_z = 16'($urandom_range(0, 2000)) - 16'd1000;
				f.v1_x = f.v0_x + 16'($urandom_range(0, 200)) - 16'd100;
				f.v1_y = f.v0_y + 16'($urandom_range(0, 200)) - 16'd100;
				f.v1_z = f.v0_z + 16'($urandom_range(0, 200)) - 16'd100;
				f.v2_x = f.v0_x + 16'd3 * (f.v1_x - f.v0_x);
				f.v2_y = f.v0_y + 16'd3 * (f.v1_y - f.v0_y);
				f.v2_z = f.v0_z + 16'd3 * (f.v1_z - f.v0_z);
			end
			2: begin
				// axis-aligned face, two cross components zero
				f.v1_z = f.v0_z;
				f.v2_z = f.v0_z;
			end
			default: ;
		endcase
		return f;
	endfunction

	// send n faces in bursts of random length with random gaps
	task automatic send_bursts(int n);
		int left;
		int kind;
		left = 0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) begin
				left = $urandom_range(1, 40);
				if (max_gap > 0 && $urandom_range(0, 3) != 0)
					pause_sender($urandom_range(1, max_gap));
			end
			left--;
			kind = $urandom_range(0, 9);
			send_face(random_face(kind < 4 ? 3 : kind < 6 ? 0 : kind < 8 ? 2 : 1));
		end
	endtask

	// sender pauses until every expected normal has come
	task automatic drain;
		face_valid <= 1'b0;
		while (expected_normals.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed;
		face_t f;
		// all corners equal: degenerate
		f = '0;
		send_face(f);
		// unit triangle in the xy plane, +z normal
		f = '0; f.v1_x = 16'sd256; f.v2_y = 16'sd256;
		send_face(f);
		// swapped corners, -z normal
		f = '0; f.v1_y = 16'sd256; f.v2_x = 16'sd256;
		send_face(f);
		// yz and zx planes
		f = '0; f.v1_y = 16'sd1; f.v2_z = 16'sd1;
		send_face(f);
		f = '0; f.v1_z = 16'sd1; f.v2_x = 16'sd1;
		send_face(f);
		// extremes of the coordinate range
		f = '0; f.v0_x = -16'sd32768; f.v0_y = -16'sd32768; f.v0_z = -16'sd32768;
		f.v1_x = 16'sd32767; f.v1_y = -16'sd32768; f.v1_z = -16'sd32768;
		f.v2_x = -16'sd32768; f.v2_y = 16'sd32767; f.v2_z = 16'sd32767;
		send_face(f);
		f = {9{16'h7fff}}; f.v1_x = 16'h8000; f.v2_y = 16'h8000;
		send_face(f);
		f = {9{16'h8000}}; f.v1_x = 16'h7fff; f.v1_y = 16'h7fff; f.v2_z = 16'h7fff;
		send_face(f);
		// collinear corners
		f = '0; f.v1_x = 16'sd5; f.v1_y = 16'sd7; f.v2_x = -16'sd10; f.v2_y = -16'sd14;
		send_face(f);
		// two corners coincide
		f = {9{16'h1234}}; f.v2_x = 16'h7000;
		send_face(f);
		// diagonal normal, all components equal
		f = '0; f.v0_x = 16'sd100; f.v1_y = 16'sd100; f.v2_z = 16'sd100;
		send_face(f);
		// all bits set and alternating patterns
		f = {9{16'hffff}}; f.v1_x = 16'h5555; f.v2_y = 16'haaaa;
		send_face(f);
		f = {9{16'haaaa}}; f.v1_z = 16'h5555; f.v2_x = 16'h0001;
		send_face(f);
		drain();
	endtask

	task automatic test_random_flow;
		max_gap = 8;
		random_stall = 1'b1;
		send_bursts(700);
		drain();
	endtask

	task automatic test_full_rate;
		max_gap = 0;
		random_stall = 1'b0;
		send_bursts(400);
		drain();
	endtask

	// receiver holds off long enough for the pipe to fill and stall the input
	task automatic test_back_pressure;
		max_gap = 3;
		random_stall = 1'b1;
		hold_off = 1'b1;
		send_bursts(600);
		drain();
	endtask

	// receiver: random stall pattern plus one long hold-off
	initial begin
		int hold_cycles;
		norm_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				hold_cycles = 300;
				norm_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
			end
			if (random_stall)
				norm_stall <= ($urandom_range(0, 99) < 30);
			else
				norm_stall <= 1'b0;
		end
	end

	// checker: compare each norm transaction with the oldest expectation
	always @(posedge clk) begin
		norm_t want;
		if (arst_n && norm_valid && !norm_stall) begin
			if (expected_normals.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected norm transaction %h", norm);
			end else begin
				want = expected_normals.pop_front();
				if (norm !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("norm mismatch: expected x=%0d y=%0d z=%0d deg=%b, got x=%0d y=%0d z=%0d deg=%b",
							want.normal_x, want.normal_y, want.normal_z, want.degenerate,
							norm.normal_x, norm.normal_y, norm.normal_z, norm.degenerate);
				end
			end
		end
	end

	// cycle counter with a generous limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		hold_off = 1'b0;
		random_stall = 1'b0;
		max_gap = 0;
		arst_n = 1'b0;
		face_valid = 1'b0;
		face = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_flow();
		test_full_rate();
		test_back_pressure();
		// let the pipe settle past its latency
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_normals.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
